FILE: hdl/nrlc_pkg.sv
// Shared types, constants and helper functions for the reply line checker.
// Used by nrlc_parser and nmea_reply_line_checker_unit; no dependencies.
package nrlc_pkg;

	localparam int MAX_LINE   = 128;
	localparam int MAX_FIELDS = 16;

	localparam int CNT_W = $clog2(MAX_LINE);
	localparam int FLD_W = 4;
	localparam int PFX_W = 24;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_R      = 8'h52;

	typedef enum logic [2:0] {
		KIND_CMD     = 3'd0,
		KIND_FIELD   = 3'd1,
		KIND_SEP     = 3'd2,
		KIND_TRAILER = 3'd3,
		KIND_NEWLINE = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_OK       = 3'd1,
		ST_ERR      = 3'd2,
		ST_BAD      = 3'd3,
		ST_LONG     = 3'd4,
		ST_FIELDS   = 3'd5,
		ST_NOFIELD  = 3'd6,
		ST_IGNORED  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		ERR_IDLE    = 3'd0,
		ERR_WANT_E  = 3'd1,
		ERR_WANT_R1 = 3'd2,
		ERR_WANT_R2 = 3'd3,
		ERR_MATCHED = 3'd4,
		ERR_FAILED  = 3'd5
	} err_step_t;

	typedef struct packed {
		logic [7:0]       running_xor;
		logic [CNT_W-1:0] char_count;
		logic [23:0]      last_three;
		logic             starts_with_dollar;
		logic             prefix_matches;
		logic             prefix_done;
		logic             in_command_word;
		logic             star_seen;
		logic [FLD_W-1:0] current_field;
		logic             fields_exceeded;
		err_step_t        err_step;
		logic             line_too_long;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		running_xor:        8'd0,
		char_count:         '0,
		last_three:         24'd0,
		starts_with_dollar: 1'b0,
		prefix_matches:     1'b1,
		prefix_done:        1'b0,
		in_command_word:    1'b1,
		star_seen:          1'b0,
		current_field:      '0,
		fields_exceeded:    1'b0,
		err_step:           ERR_IDLE,
		line_too_long:      1'b0
	};

	typedef struct packed {
		logic [7:0]       echo_byte;
		logic [FLD_W-1:0] field_index;
		kind_t            char_kind;
		logic             line_done;
		status_t          line_status;
		logic [FLD_W-1:0] field_count;
	} result_t;

	// Lowercase hex character for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};
		end
		return c;
	endfunction

	// Expected character at a prefix position; position 0 is the top byte.
	function automatic logic [7:0] prefix_byte(input logic [PFX_W-1:0] pfx,
			input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0: begin
				c = pfx[23:16];
			end
			2'd1: begin
				c = pfx[15:8];
			end
			2'd2: begin
				c = pfx[7:0];
			end
			default: begin
				c = pfx[23:16];
			end
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/nrlc_parser.sv
// Per-line state of the reply checker and the combinational byte classifier.
// Depends on nrlc_pkg for the state and result structs and character codes.
module nrlc_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 rx_byte,
	input  logic [nrlc_pkg::PFX_W-1:0] prefix,
	output nrlc_pkg::result_t          res
);
	import nrlc_pkg::*;

	line_state_t      st_q;
	line_state_t      st_nxt;
	status_t          verdict;
	logic             pm;
	logic [7:0]       star_c;
	logic [7:0]       hi_c;
	logic [7:0]       lo_c;
	logic [7:0]       cs;
	logic [FLD_W:0]   field_inc;
	logic [7:0]       err_char;

	// Verdict for the line held in st_q, used only on a newline.
	always_comb begin
		pm     = st_q.prefix_matches;
		star_c = st_q.last_three[23:16];
		hi_c   = st_q.last_three[15:8];
		lo_c   = st_q.last_three[7:0];
		cs     = st_q.running_xor ^ star_c ^ hi_c ^ lo_c;
		if (pm && !st_q.prefix_done && st_q.char_count < CNT_W'(3)) begin
			pm = (prefix_byte(prefix, st_q.char_count[1:0]) == 8'd0);
		end
		if (st_q.line_too_long) begin
			verdict = ST_LONG;
		end else if (!pm) begin
			verdict = ST_IGNORED;
		end else if (st_q.char_count <= CNT_W'(5) || !st_q.starts_with_dollar ||
				star_c != CH_STAR || hi_c != hex_char(cs[7:4]) ||
				lo_c != hex_char(cs[3:0])) begin
			verdict = ST_BAD;
		end else if (st_q.fields_exceeded) begin
			verdict = ST_FIELDS;
		end else if (st_q.current_field == '0) begin
			verdict = ST_NOFIELD;
		end else if (st_q.err_step == ERR_MATCHED) begin
			verdict = ST_ERR;
		end else begin
			verdict = ST_OK;
		end
	end

	always_comb begin
		case (st_q.err_step)
			ERR_WANT_E: begin
				err_char = CH_E;
			end
			default: begin
				err_char = CH_R;
			end
		endcase
	end

	assign field_inc = {1'b0, st_q.current_field} + (FLD_W+1)'(1);

	always_comb begin
		st_nxt          = st_q;
		res.echo_byte   = rx_byte;
		res.field_index = st_q.current_field;
		res.char_kind   = KIND_FIELD;
		res.line_done   = 1'b0;
		res.line_status = ST_BUSY;
		res.field_count = '0;
		if (rx_byte == CH_LF) begin
			res.char_kind   = KIND_NEWLINE;
			res.line_done   = 1'b1;
			res.line_status = verdict;
			res.field_count = st_q.current_field;
			st_nxt          = LINE_CLEAR;
		end else if (st_q.line_too_long ||
				st_q.char_count >= CNT_W'(MAX_LINE - 1)) begin
			// The byte does not fit: it is dropped and only the flag changes.
			st_nxt.line_too_long = 1'b1;
		end else begin
			if (st_q.char_count == '0 && rx_byte == CH_DOLLAR) begin
				st_nxt.starts_with_dollar = 1'b1;
			end
			if (st_q.char_count < CNT_W'(3) && st_q.prefix_matches &&
					!st_q.prefix_done) begin
				if (rx_byte != prefix_byte(prefix, st_q.char_count[1:0])) begin
					st_nxt.prefix_matches = 1'b0;
				end else if (rx_byte == 8'd0) begin
					st_nxt.prefix_done = 1'b1;
				end
			end
			if (st_q.char_count != '0) begin
				st_nxt.running_xor = st_q.running_xor ^ rx_byte;
			end
			st_nxt.last_three = {st_q.last_three[15:0], rx_byte};
			st_nxt.char_count = st_q.char_count + CNT_W'(1);
			if (st_q.err_step == ERR_WANT_E || st_q.err_step == ERR_WANT_R1 ||
					st_q.err_step == ERR_WANT_R2) begin
				if (rx_byte == err_char) begin
					st_nxt.err_step = err_step_t'(st_q.err_step + 3'd1);
				end else begin
					st_nxt.err_step = ERR_FAILED;
				end
			end
			if (st_q.star_seen) begin
				res.char_kind = KIND_TRAILER;
			end else if (rx_byte == CH_STAR) begin
				st_nxt.star_seen = 1'b1;
				res.char_kind    = KIND_TRAILER;
			end else if (st_q.in_command_word) begin
				if (rx_byte == CH_SPACE) begin
					st_nxt.in_command_word = 1'b0;
					st_nxt.current_field   = FLD_W'(1);
					st_nxt.err_step        = ERR_WANT_E;
					res.char_kind          = KIND_SEP;
				end else begin
					res.char_kind = KIND_CMD;
				end
			end else if (rx_byte == CH_COMMA) begin
				res.char_kind = KIND_SEP;
				if (!st_q.fields_exceeded) begin
					if (field_inc >= (FLD_W+1)'(MAX_FIELDS)) begin
						st_nxt.fields_exceeded = 1'b1;
					end else begin
						st_nxt.current_field = field_inc[FLD_W-1:0];
					end
				end
			end else begin
				res.char_kind = KIND_FIELD;
			end
			res.field_index = st_nxt.current_field;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LINE_CLEAR;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule

FILE: hdl/nmea_reply_line_checker_unit.sv
// Top level of the reply line checker: input stage, result register, prefix register.
// Depends on nrlc_pkg and nrlc_parser.
//
// Usage: reply characters arrive one per beat on the s_axis slave channel and every
// beat produces exactly one result beat on the m_axis master channel. The result
// echoes the character, tags it with its field index and a kind (tuser), and on the
// newline that ends a line raises tlast together with the line verdict and the index
// of the last field opened. On every other beat status and field count are zero.
// The expected three-character prefix is loaded through cfg_wen/cfg_wdata while the
// block is idle; lines that do not start with it still get a newline beat, status 7 (4 if too long).
//
// Flow: an accepted input beat is held in the input stage, classified there by the
// parser, and its result is registered in the output register for the receiver.
// Throughput is one beat per cycle while the receiver is ready: the input stage and
// the output register form a two-deep pipeline, and the classifier is short
// combinational logic between them. When the receiver stalls the result register
// holds; one more input beat can still be taken into the input stage, after which
// s_axis_tready drops until the output beat is taken.
//
// Reset clears all line state, empties both stages and sets the prefix to zero.
module nmea_reply_line_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [23:0] cfg_wdata,      // expected_prefix, first character in [23:16]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] echo_byte, [11:8] field_index,
	                                    // [14:12] line_status, [18:15] field_count
	output logic [2:0]  m_axis_tuser,   // [2:0] char_kind
	output logic        m_axis_tlast    // line_done
);
	import nrlc_pkg::*;

	logic [PFX_W-1:0] prefix_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_s2;
	result_t          res_s2;
	result_t          res;
	logic             adv;

	// The parser works on the beat held in the input stage whenever the output
	// register is empty or is being emptied in the same cycle.
	assign adv           = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
		end else if (cfg_wen) begin
			prefix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	nrlc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.prefix  (prefix_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2.field_count, res_s2.line_status,
		res_s2.field_index, res_s2.echo_byte};
	assign m_axis_tuser  = res_s2.char_kind;
	assign m_axis_tlast  = res_s2.line_done;

	// A newline result always carries the newline kind and a final field count
	// equal to its own field index.
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && res_s2.line_done |->
			res_s2.char_kind == KIND_NEWLINE && res_s2.field_count == res_s2.field_index)
		else $error("newline result with wrong kind or field count");

	// Only a newline result carries a verdict or a field count.
	a_busy_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !res_s2.line_done |->
			res_s2.line_status == ST_BUSY && res_s2.field_count == '0)
		else $error("verdict reported on a byte that is not a newline");

	// A beat waiting in the input stage stays put while the output is blocked.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a beat during a stall");

	// Every processed beat lands in the output register.
	a_s2_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_s2)
		else $error("processed beat did not reach the output register");

endmodule

FILE: sim/nmea_reply_line_checker_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for nmea_reply_line_checker_unit: a directed table of reply lines,
// then random lines over five prefix and flow-control phases, all checked beat by beat.
// Depends on nrlc_pkg and the nmea_reply_line_checker_unit RTL.
module nmea_reply_line_checker_unit_tb;
	import nrlc_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 4;
	// The pipeline is two stages deep. This many quiet cycles before a prefix write
	// or the final verdict leaves room for anything still in flight.
	localparam int DRAIN_CYCLES = 4;
	// The longest correct gap without any beat is the forced receiver hold-off
	// (HOLD_CYCLES) plus the drain (DRAIN_CYCLES). Random stalls at 53 percent almost
	// never last long; the limit below is far longer than either.
	localparam int HOLD_CYCLES  = 80;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_BEATS  = 150;
	localparam int N_PHASES     = 5;
	localparam int DRILL_N      = 26;

	// One row of the directed table. It is either a prefix write or a beat to send.
	// A typed row carries the verdict expected on its newline.
	typedef struct {
		bit          is_cfg;
		logic [23:0] val;
		bit          typed;
		status_t     st;
		logic [3:0]  nfld;
	} drill_row_t;

	typedef enum {
		SHAPE_GOOD,
		SHAPE_BROKEN,
		SHAPE_NOISE,
		SHAPE_LONG,
		SHAPE_CROWDED
	} line_shape_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wen       = 1'b0;
	logic [23:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;   // [7:0] echo_byte, [11:8] field_index,
	                             // [14:12] line_status, [18:15] field_count
	logic [2:0]  m_axis_tuser;   // [2:0] char_kind
	logic        m_axis_tlast;   // line_done

	// Shadow of the line state, kept in step with every accepted input beat.
	logic [23:0] pfx_reg;
	logic [7:0]  xor_acc;
	logic [7:0]  stored_n;
	logic [23:0] tail3;
	bit          dollar_first;
	bit          pfx_ok;
	bit          pfx_ended;
	bit          in_cmd;
	bit          star_hit;
	logic [3:0]  fld;
	bit          fld_over;
	err_step_t   err_st;
	bit          overflow;

	result_t     pending_results[$];
	result_t     oldest;
	logic [7:0]  line_buf[$];
	int          fail_count  = 0;
	int          beats_sent  = 0;
	int          idle_pct    = 0;
	int          stall_pct   = 0;
	int          hold_left   = 0;
	int          quiet_cycles = 0;

	int          send_idle_by_phase [N_PHASES] = '{0, 53, 0, 20, 0};
	int          stall_by_phase     [N_PHASES] = '{0, 0, 53, 20, 0};
	logic [23:0] phase_prefix       [N_PHASES];

	// Short walk through every character kind and the main verdicts. The first
	// four beats run under the reset prefix of zero: a zero byte ends the prefix
	// comparison early and matches, while 0xFF fails it and the line is ignored.
	drill_row_t drill [DRILL_N] = '{
		'{1'b0, 24'h000000, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00000A, 1'b1, ST_BAD,     4'd0},
		'{1'b0, 24'h0000FF, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00000A, 1'b1, ST_IGNORED, 4'd0},
		'{1'b1, 24'h24504D, 1'b0, ST_BUSY,    4'd0},
		// "$PM ,A*50": two fields, good checksum.
		'{1'b0, 24'h000024, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000050, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00004D, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000020, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00002C, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000041, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00002A, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000035, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000030, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00000A, 1'b1, ST_OK,      4'd2},
		// "$PM ERR*78": an error reply in field one.
		'{1'b0, 24'h000024, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000050, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00004D, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000020, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000045, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000052, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000052, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00002A, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000037, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h000038, 1'b0, ST_BUSY,    4'd0},
		'{1'b0, 24'h00000A, 1'b1, ST_ERR,     4'd1}
	};

	nmea_reply_line_checker_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [7:0] hex_nib(input logic [3:0] n);
		string digits;
		digits = "0123456789abcdef";
		return digits[n];
	endfunction

	// Printable filler that never opens a field or ends parsing.
	function automatic logic [7:0] text_char();
		logic [7:0] c;
		c = 8'($urandom_range(33, 126));
		if (c == CH_STAR || c == CH_COMMA) begin
			c = 8'h41;
		end
		return c;
	endfunction

	function automatic void clear_line_state();
		xor_acc      = '0;
		stored_n     = '0;
		tail3        = '0;
		dollar_first = 1'b0;
		pfx_ok       = 1'b1;
		pfx_ended    = 1'b0;
		in_cmd       = 1'b1;
		star_hit     = 1'b0;
		fld          = '0;
		fld_over     = 1'b0;
		err_st       = ERR_IDLE;
		overflow     = 1'b0;
	endfunction

	// Advances the shadow line state by one received character and returns the
	// result beat that character must produce.
	function automatic result_t scan_byte(input logic [7:0] b);
		result_t    r;
		kind_t      kind;
		status_t    st;
		bit         match;
		logic [7:0] star_c, hi_c, lo_c, sum;
		r.echo_byte   = b;
		r.line_done   = 1'b0;
		r.line_status = ST_BUSY;
		r.field_count = '0;

		if (b == CH_LF) begin
			// A line shorter than the prefix still matches when the prefix ends
			// in a zero byte right where the line ends.
			match = pfx_ok;
			if (pfx_ok && !pfx_ended && stored_n < 3) begin
				match = (pfx_reg[23 - 8*int'(stored_n) -: 8] == 8'h00);
			end
			star_c = tail3[23:16];
			hi_c   = tail3[15:8];
			lo_c   = tail3[7:0];
			sum    = xor_acc ^ star_c ^ hi_c ^ lo_c;
			if (overflow) begin
				st = ST_LONG;
			end else if (!match) begin
				st = ST_IGNORED;
			end else if (stored_n <= 5 || !dollar_first || star_c != CH_STAR ||
					hi_c != hex_nib(sum[7:4]) || lo_c != hex_nib(sum[3:0])) begin
				st = ST_BAD;
			end else if (fld_over) begin
				st = ST_FIELDS;
			end else if (fld == 0) begin
				st = ST_NOFIELD;
			end else if (err_st == ERR_MATCHED) begin
				st = ST_ERR;
			end else begin
				st = ST_OK;
			end
			r.field_index = fld;
			r.char_kind   = KIND_NEWLINE;
			r.line_done   = 1'b1;
			r.line_status = st;
			r.field_count = fld;
			clear_line_state();
			return r;
		end

		// Once the store is full every further character is dropped untouched.
		if (overflow || stored_n >= MAX_LINE - 1) begin
			overflow      = 1'b1;
			r.field_index = fld;
			r.char_kind   = KIND_FIELD;
			return r;
		end

		if (stored_n == 0 && b == CH_DOLLAR) begin
			dollar_first = 1'b1;
		end
		if (stored_n < 3 && pfx_ok && !pfx_ended) begin
			if (b != pfx_reg[23 - 8*int'(stored_n) -: 8]) begin
				pfx_ok = 1'b0;
			end else if (b == 8'h00) begin
				pfx_ended = 1'b1;
			end
		end
		if (stored_n >= 1) begin
			xor_acc = xor_acc ^ b;
		end
		tail3    = {tail3[15:0], b};
		stored_n = stored_n + 8'd1;

		case (err_st)
			ERR_WANT_E: begin
				err_st = (b == CH_E) ? ERR_WANT_R1 : ERR_FAILED;
			end
			ERR_WANT_R1: begin
				err_st = (b == CH_R) ? ERR_WANT_R2 : ERR_FAILED;
			end
			ERR_WANT_R2: begin
				err_st = (b == CH_R) ? ERR_MATCHED : ERR_FAILED;
			end
			default: begin
			end
		endcase

		if (star_hit) begin
			kind = KIND_TRAILER;
		end else if (b == CH_STAR) begin
			star_hit = 1'b1;
			kind     = KIND_TRAILER;
		end else if (in_cmd) begin
			if (b == CH_SPACE) begin
				in_cmd = 1'b0;
				fld    = 4'd1;
				err_st = ERR_WANT_E;
				kind   = KIND_SEP;
			end else begin
				kind = KIND_CMD;
			end
		end else if (b == CH_COMMA) begin
			kind = KIND_SEP;
			// Field index saturates one below the limit; later commas open nothing.
			if (!fld_over) begin
				if (int'(fld) + 1 >= MAX_FIELDS) begin
					fld_over = 1'b1;
				end else begin
					fld = fld + 4'd1;
				end
			end
		end else begin
			kind = KIND_FIELD;
		end
		r.field_index = fld;
		r.char_kind   = kind;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h",
			$realtime, what, got, want);
	endtask

	// Offers one character, idling at random first, and records what it must
	// produce once the beat is taken. A typed result replaces the prediction.
	task automatic send_beat(input logic [7:0] b, input bit typed, input result_t typed_res);
		result_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predicted = scan_byte(b);
		pending_results.push_back(typed ? typed_res : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	// The prefix is only changed with the pipeline empty and at a line boundary.
	// The sender stops offering first so the last beat is not taken twice.
	task automatic load_prefix(input logic [23:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		pfx_reg    = v;
	endtask

	// Builds one newline-terminated reply into line_buf.
	task automatic build_line(input line_shape_t shape);
		logic [7:0] c, sum, lo_c;
		int         len, n_fields;
		line_buf = {};
		case (shape)
			SHAPE_NOISE: begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					line_buf.push_back(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 2) == 0) begin
					line_buf[0] = pfx_reg[23:16];
				end
			end
			SHAPE_LONG: begin
				len = $urandom_range(MAX_LINE - 4, MAX_LINE + 12);
				for (int i = 0; i < len; i++) begin
					line_buf.push_back(text_char());
				end
			end
			default: begin
				// Reply layout: the configured prefix up to its first zero byte, a
				// command word, fields, then '*' and a checksum that is sometimes wrong.
				for (int i = 0; i < 3; i++) begin
					c = pfx_reg[23 - 8*i -: 8];
					if (c == 8'h00) begin
						break;
					end
					line_buf.push_back(c);
				end
				if (line_buf.size() == 0) begin
					line_buf.push_back(CH_DOLLAR);
				end
				len = $urandom_range(0, 3);
				for (int i = 0; i < len; i++) begin
					line_buf.push_back(8'($urandom_range(65, 90)));
				end
				if (shape == SHAPE_CROWDED) begin
					n_fields = $urandom_range(MAX_FIELDS - 1, MAX_FIELDS + 3);
				end else begin
					n_fields = $urandom_range(0, 5);
				end
				if (n_fields > 0) begin
					line_buf.push_back(CH_SPACE);
					if ($urandom_range(0, 3) == 0) begin
						line_buf.push_back(CH_E);
						line_buf.push_back(CH_R);
						line_buf.push_back(($urandom_range(0, 3) == 0) ? 8'h58 : CH_R);
					end
					for (int f = 1; f <= n_fields; f++) begin
						if (f > 1) begin
							line_buf.push_back(CH_COMMA);
						end
						len = $urandom_range(0, 4);
						for (int i = 0; i < len; i++) begin
							line_buf.push_back(text_char());
						end
					end
				end
				sum = '0;
				for (int i = 1; i < line_buf.size(); i++) begin
					sum = sum ^ line_buf[i];
				end
				lo_c = hex_nib(sum[3:0]);
				if ($urandom_range(0, 6) == 0) begin
					lo_c = lo_c ^ 8'h01;
				end
				line_buf.push_back(CH_STAR);
				line_buf.push_back(hex_nib(sum[7:4]));
				line_buf.push_back(lo_c);
				if (shape == SHAPE_BROKEN) begin
					line_buf[$urandom_range(0, line_buf.size() - 1)] =
						8'($urandom_range(0, 255));
				end
			end
		endcase
		line_buf.push_back(CH_LF);
	endtask

	// Receiver: random stalls at the phase rate, or a forced hold-off counted
	// down here, which lets the block fill up and push back on its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Result checker: every result beat is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result beat", int'(m_axis_tdata), 0);
			end else begin
				oldest = pending_results.pop_front();
				if (m_axis_tdata[7:0] != oldest.echo_byte) begin
					flag_mismatch("echo_byte", m_axis_tdata[7:0], oldest.echo_byte);
				end
				if (m_axis_tdata[11:8] != oldest.field_index) begin
					flag_mismatch("field_index", m_axis_tdata[11:8], oldest.field_index);
				end
				if (m_axis_tuser != oldest.char_kind) begin
					flag_mismatch("char_kind", m_axis_tuser, oldest.char_kind);
				end
				if (m_axis_tlast != oldest.line_done) begin
					flag_mismatch("line_done", m_axis_tlast, oldest.line_done);
				end
				if (m_axis_tdata[14:12] != oldest.line_status) begin
					flag_mismatch("line_status", m_axis_tdata[14:12], oldest.line_status);
				end
				if (m_axis_tdata[18:15] != oldest.field_count) begin
					flag_mismatch("field_count", m_axis_tdata[18:15], oldest.field_count);
				end
			end
		end
	end

	// Watchdog: any cycle without a beat on either side counts toward the limit.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("nmea_reply_line_checker_unit_tb: FAIL");
		$finish;
	end

	initial begin
		result_t     typed_res;
		line_shape_t shape;
		int          pick, n_line;

		pfx_reg = '0;
		clear_line_state();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table, no idling on either side.
		foreach (drill[i]) begin
			if (drill[i].is_cfg) begin
				load_prefix(drill[i].val);
			end else begin
				typed_res = '{echo_byte: CH_LF, field_index: drill[i].nfld,
					char_kind: KIND_NEWLINE, line_done: 1'b1,
					line_status: drill[i].st, field_count: drill[i].nfld};
				send_beat(drill[i].val[7:0], drill[i].typed, typed_res);
			end
		end

		// Random phases. The prefixes cover a typical one, one that ends after
		// its first character, all ones, all zeros and a random one.
		phase_prefix[0] = 24'h24504D;
		phase_prefix[1] = 24'h240000;
		phase_prefix[2] = 24'hFFFFFF;
		phase_prefix[3] = 24'h000000;
		phase_prefix[4] = {CH_DOLLAR, 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};

		for (int ph = 0; ph < N_PHASES; ph++) begin
			load_prefix(phase_prefix[ph]);
			@(posedge clk);
			idle_pct  = send_idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			if (ph == N_PHASES - 1) begin
				hold_left = HOLD_CYCLES;
			end
			@(negedge clk);
			beats_sent = 0;
			n_line     = 0;
			while (beats_sent < PHASE_BEATS) begin
				// Make sure a crowded line and an overlong line appear every run.
				if (n_line == 0 && ph == 0) begin
					shape = SHAPE_CROWDED;
				end else if (n_line == 0 && ph == 2) begin
					shape = SHAPE_LONG;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 3) begin
						shape = SHAPE_LONG;
					end else if (pick < 18) begin
						shape = SHAPE_NOISE;
					end else if (pick < 30) begin
						shape = SHAPE_BROKEN;
					end else if (pick < 38) begin
						shape = SHAPE_CROWDED;
					end else begin
						shape = SHAPE_GOOD;
					end
				end
				build_line(shape);
				foreach (line_buf[i]) begin
					send_beat(line_buf[i], 1'b0, typed_res);
				end
				n_line++;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("nmea_reply_line_checker_unit_tb: PASS");
		end else begin
			$display("nmea_reply_line_checker_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/nrlc_pkg.sv
hdl/nrlc_parser.sv
hdl/nmea_reply_line_checker_unit.sv
sim/nmea_reply_line_checker_unit_tb.sv
